[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/isr_pkg.sv]
`timescale 1ns / 1ps

package isr_pkg;

    localparam int POS_W = 33;

    typedef enum logic [1:0]
    {
        OP_ADD       = 2'd0,
        OP_GET       = 2'd1,
        OP_PROCESSED = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [2:0]
    {
        ST_OK     = 3'd0,
        ST_NONE   = 3'd1,
        ST_BEHIND = 3'd2,
        ST_FULL   = 3'd3,
        ST_NOPROG = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_PURGE,
        S_COMMIT
    } ctrl_state_t;

    typedef struct packed
    {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] frame_offset;
        logic [31:0] header_offset;
        logic [15:0] packet;
    } seg_t;

    typedef struct packed
    {
        logic load;
        logic clr_cnt;
        logic scan;
        logic purge;
        logic commit;
    } dp_cmd_t;

    typedef struct packed
    {
        logic scan_done;
        logic out_free;
        op_t  op;
    } dp_sts_t;

endpackage

[hw/rtl/isr_datapath.sv]
`timescale 1ns / 1ps

// Segment table, delivered offset, scan compare logic and result register.
module isr_datapath
    import isr_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op_in,
    input  seg_t               seg_in,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic               res_valid,
    input  logic               res_ready,
    output status_t            res_status,
    output seg_t               res_seg,
    output logic [POS_W-1:0]   res_pos
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    seg_t               mem [ENTRIES];

    op_t                op_reg;
    seg_t               seg_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ENTRIES-1:0] used_reg;
    logic [CW-1:0]      cnt_reg;
    seg_t               rd_seg_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               rd_v_reg;
    logic               hit_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic               hit_less_reg;
    seg_t               hit_seg_reg;
    logic               free_v_reg;
    logic [AW-1:0]      free_idx_reg;
    logic               res_valid_reg;
    status_t            res_status_reg;
    seg_t               res_seg_reg;

    logic               rd_used;
    logic [POS_W-1:0]   rd_end;
    logic               rd_le_pos;
    logic               rd_live;
    logic               rd_lower;
    logic [POS_W-1:0]   in_end;
    logic               in_behind;
    status_t            commit_status;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    assign rd_used   = used_reg[rd_idx_reg];
    assign rd_end    = {1'b0, rd_seg_reg.start} + {1'b0, rd_seg_reg.length};
    assign rd_le_pos = {1'b0, rd_seg_reg.start} <= pos_reg;
    assign rd_live   = rd_end > pos_reg;
    assign rd_lower  = !hit_reg || (rd_seg_reg.start < hit_seg_reg.start);
    assign in_end    = {1'b0, seg_reg.start} + {1'b0, seg_reg.length};
    assign in_behind = {1'b0, seg_reg.start} <= pos_reg;

    // Outcome of the operation once the scans are finished.
    always_comb
    begin
        commit_status = ST_OK;
        wr_en         = 1'b0;
        wr_addr       = free_idx_reg;
        unique case (op_reg)
            OP_ADD:
            begin
                if (in_behind)
                begin
                    commit_status = ST_BEHIND;
                end
                else if (hit_reg)
                begin
                    wr_en   = hit_less_reg;
                    wr_addr = hit_idx_reg;
                end
                else if (free_v_reg)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    commit_status = ST_FULL;
                end
            end
            OP_GET:
            begin
                if (!hit_reg)
                begin
                    commit_status = ST_NONE;
                end
            end
            OP_PROCESSED:
            begin
                if (in_end <= pos_reg)
                begin
                    commit_status = ST_NOPROG;
                end
            end
            default:
            begin
                commit_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_in;
            seg_reg <= seg_in;
        end
        if (cmd.scan)
        begin
            rd_seg_reg <= mem[cnt_reg[AW-1:0]];
            rd_idx_reg <= cnt_reg[AW-1:0];
        end
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= seg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            used_reg      <= '0;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.scan;
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                hit_reg    <= 1'b0;
                free_v_reg <= 1'b0;
            end
            else if (rd_v_reg && !cmd.purge)
            begin
                // First pass: look for an equal start or a free slot on an
                // add, and for the lowest-start live segment on a get.
                if (!rd_used)
                begin
                    if (!free_v_reg)
                    begin
                        free_v_reg <= 1'b1;
                    end
                end
                else if (op_reg == OP_ADD)
                begin
                    if (rd_seg_reg.start == seg_reg.start)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                else if (rd_le_pos && rd_live && rd_lower)
                begin
                    hit_reg <= 1'b1;
                end
            end
            else if (rd_v_reg && cmd.purge)
            begin
                // Second pass of a get: drop stale segments that sort
                // below the one being returned.
                if (rd_used && rd_le_pos && !rd_live && rd_lower)
                begin
                    used_reg[rd_idx_reg] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                if (op_reg == OP_ADD && wr_en)
                begin
                    used_reg[wr_addr] <= 1'b1;
                end
                if (op_reg == OP_GET && hit_reg)
                begin
                    used_reg[hit_idx_reg] <= 1'b0;
                end
                if (op_reg == OP_PROCESSED && commit_status == ST_OK)
                begin
                    pos_reg <= in_end;
                end
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload side of the first pass and of the result register; no reset needed.
    always_ff @(posedge clk)
    begin
        if (rd_v_reg && !cmd.purge && !cmd.load)
        begin
            if (!rd_used)
            begin
                if (!free_v_reg)
                begin
                    free_idx_reg <= rd_idx_reg;
                end
            end
            else if (op_reg == OP_ADD)
            begin
                if (rd_seg_reg.start == seg_reg.start)
                begin
                    hit_idx_reg  <= rd_idx_reg;
                    hit_less_reg <= rd_seg_reg.length < seg_reg.length;
                end
            end
            else if (rd_le_pos && rd_live && rd_lower)
            begin
                hit_idx_reg <= rd_idx_reg;
                hit_seg_reg <= rd_seg_reg;
            end
        end
        if (cmd.commit)
        begin
            res_status_reg <= commit_status;
            if (op_reg == OP_GET && hit_reg)
            begin
                res_seg_reg <= hit_seg_reg;
            end
            else
            begin
                res_seg_reg <= '0;
            end
        end
    end

    assign sts.scan_done = cnt_reg == CW'(ENTRIES);
    assign sts.out_free  = !res_valid_reg || res_ready;
    assign sts.op        = op_reg;

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_seg    = res_seg_reg;
    assign res_pos    = pos_reg;

endmodule

[hw/rtl/isr_ctrl.sv]
`timescale 1ns / 1ps

// Sequencer: load, table scan for an add or get, purge scan for a get, commit.
module isr_ctrl
    import isr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  op_t     in_op,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.clr_cnt = 1'b1;
                    if (in_op == OP_ADD || in_op == OP_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.op == OP_GET)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_PURGE;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_PURGE:
            begin
                cmd.purge = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/inorder_segment_reassembly.sv]
`timescale 1ns / 1ps
// Processed and unused codes go straight from load to commit; an add sweeps the table once and
// a get sweeps it twice before its result is committed.
// Items are taken one at a time: the next is accepted only once the last has committed, which
// waits for the table sweeps of the single read port and for the output register to be free.
// Reset: rst_n clears the delivered offset, all slot valid bits and the control.
module inorder_segment_reassembly
    import isr_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: start_offset, length, frame_offset, header_offset,
    // packet_handle.
    input  logic [143:0] s_tdata,
    // Fields from bit 0: operation.
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: out_start, out_length, out_frame_offset,
    // out_header_offset, out_packet, delivered_offset, zero fill.
    output logic [183:0] m_tdata,
    // Fields from bit 0: status.
    output logic [2:0]   m_tuser
);

    // An item is loaded into the datapath when the sequencer is idle. Each
    // add or get then sweeps the table once; a get sweeps a second time to
    // drop stale segments that sort below the one it returns. The result
    // lands in an output register, so a new item is taken while it waits.

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    seg_t             seg_in;
    seg_t             res_seg;
    status_t          res_status;
    logic [POS_W-1:0] res_pos;
    op_t              op_in;

    assign op_in                = op_t'(s_tuser);
    assign seg_in.start         = s_tdata[31:0];
    assign seg_in.length        = s_tdata[63:32];
    assign seg_in.frame_offset  = s_tdata[95:64];
    assign seg_in.header_offset = s_tdata[127:96];
    assign seg_in.packet        = s_tdata[143:128];

    isr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (op_in),
        .sts      (sts),
        .cmd      (cmd)
    );

    isr_datapath #(.ENTRIES(ENTRIES)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_in      (op_in),
        .seg_in     (seg_in),
        .cmd        (cmd),
        .sts        (sts),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_seg    (res_seg),
        .res_pos    (res_pos)
    );

    // Segment fields are zero in every result but a successful get.
    assign m_tdata = {7'd0, res_pos, res_seg.packet, res_seg.header_offset,
                      res_seg.frame_offset, res_seg.length, res_seg.start};
    assign m_tuser = res_status;

endmodule

[hw/rtl/isr_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the result stream.
module isr_port_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [2:0]   m_tuser
);

    `AST_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `AST_SAME(a_code, m_tvalid, m_tuser <= 3'd4, "status code out of range")
    `AST_SAME(a_zero, m_tvalid && m_tuser != 3'd0 && s_tvalid && s_tready,
              m_tdata[143:0] == 144'd0, "segment fields set on failed step")
    `AST_SAME(a_fill, m_tvalid, m_tdata[183:177] == 7'd0, "fill bits not zero")

endmodule

bind inorder_segment_reassembly isr_port_checker u_isr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
